@@ hw/rtl/vru_pkg.sv @@
package vru_pkg;

  // default word format, Q16.16
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // operation codes; code 7 has no member and yields an all-zero item
  typedef enum logic [2:0] {
    FN_ADD     = 3'd0,
    FN_SUB     = 3'd1,
    FN_DOT     = 3'd2,
    FN_SCALE   = 3'd3,
    FN_LENGTH  = 3'd4,
    FN_NORM    = 3'd5,
    FN_REFLECT = 3'd6
  } func_e;

  // control that travels alongside the normalize lanes into the merge stage
  typedef struct packed {
    func_e func;
    logic  len_a_zero;
    logic  len_b_zero;
  } ctl_t;

endpackage

@@ hw/rtl/vru_isqrt.sv @@
module vru_isqrt #(
  parameter int W = vru_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*W-1:0] rad_i,
  output logic [W-1:0]   root_o
);
  import vru_pkg::*;

  // one root bit per stage, floor of the square root
  logic [W:0]     rem_r  [W];
  logic [W-1:0]   root_r [W];
  logic [2*W-1:0] rad_r  [W];

  for (genvar i = 0; i < W; i++) begin : g_st
    logic [W:0]     rem_in;
    logic [W-1:0]   root_in;
    logic [2*W-1:0] rad_in;
    logic [W+1:0]   cur;
    logic [W+1:0]   trial;
    logic           ge;
    logic [W:0]     rem_nxt;
    logic [W-1:0]   root_nxt;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
    end

    // bring down two radicand bits, try 4*root+1
    assign cur      = {rem_in[W-1:0], rad_in[2*W-1 -: 2]};
    assign trial    = {root_in, 2'b01};
    assign ge       = (cur >= trial);
    assign rem_nxt  = ge ? (W+1)'(cur - trial) : (W+1)'(cur);
    assign root_nxt = {root_in[W-2:0], ge};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        rad_r[i]  <= {rad_in[2*W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_r[W-1];

endmodule

@@ hw/rtl/vru_div_lane.sv @@
module vru_div_lane #(
  parameter int W = vru_pkg::DATA_WIDTH_DEF,
  parameter int F = vru_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [W-1:0]        mag_i,
  input  logic                neg_i,
  input  logic [W-1:0]        den_i,
  output logic signed [F+1:0] q_o
);
  import vru_pkg::*;

  // (mag << F) / den, quotient known to be at most 2^F: F+1 restoring steps
  logic [W-1:0] rem_r [F+1];
  logic [F:0]   q_r   [F+1];
  logic [W-1:0] den_r [F+1];
  logic         neg_r [F+1];

  for (genvar i = 0; i <= F; i++) begin : g_st
    logic [W-1:0] rem_in;
    logic [F:0]   q_in;
    logic [W-1:0] den_in;
    logic         neg_in;
    logic         bit_in;
    logic [W:0]   cur;
    logic         ge;

    if (i == 0) begin : g_first
      assign rem_in = {1'b0, mag_i[W-1:1]};
      assign q_in   = '0;
      assign den_in = den_i;
      assign neg_in = neg_i;
      assign bit_in = mag_i[0];
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign q_in   = q_r[i-1];
      assign den_in = den_r[i-1];
      assign neg_in = neg_r[i-1];
      assign bit_in = 1'b0;
    end

    assign cur = {rem_in, bit_in};
    assign ge  = (cur >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? W'(cur - {1'b0, den_in}) : W'(cur);
        q_r[i]   <= {q_in[F-1:0], ge};
        den_r[i] <= den_in;
        neg_r[i] <= neg_in;
      end
    end
  end

  // truncation toward zero: apply the sign to the magnitude quotient
  logic signed [F+1:0] q_pos;
  assign q_pos = $signed({1'b0, q_r[F]});
  assign q_o   = neg_r[F] ? -q_pos : q_pos;

endmodule

@@ hw/rtl/vru_merge.sv @@
module vru_merge #(
  parameter int W = vru_pkg::DATA_WIDTH_DEF,
  parameter int F = vru_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  vru_pkg::ctl_t       ctl_i,
  input  logic [W-1:0]        len_i,
  input  logic [4*W+1:0]      fast_i,
  input  logic signed [F+1:0] ni_i [3],
  input  logic signed [F+1:0] nn_i [3],
  output logic [4*W+1:0]      res_o
);
  import vru_pkg::*;

  localparam int RW = ((W > F + 7) ? W : F + 7) + 1;
  localparam logic signed [RW-1:0] SAT_MAX = $signed({{(RW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [RW-1:0] SAT_MIN = $signed({{(RW-W+1){1'b1}}, {(W-1){1'b0}}});
  localparam logic [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};

  // sideband delayed over the three reflect stages
  ctl_t           ctl_r  [3];
  logic [W-1:0]   len_r  [3];
  logic [4*W+1:0] fast_r [3];

  logic signed [F+1:0]   ni1_r [3];
  logic signed [F+1:0]   nn1_r [3];
  logic signed [2*F+3:0] p1_r  [3];
  logic signed [F+1:0]   ni2_r [3];
  logic signed [F+1:0]   nn2_r [3];
  logic signed [F+3:0]   d2_r;
  logic signed [F+1:0]   ni3_r [3];
  logic signed [2*F+5:0] t3_r  [3];
  logic [4*W+1:0]        res_r;

  logic signed [2*F+5:0] dsum;
  logic signed [2*F+5:0] dsh;
  logic [4*W+1:0]        res_nxt;
  logic signed [RW-1:0]  rv;
  logic [W-1:0]          vx [3];
  logic [W-1:0]          vs;
  logic                  st;
  logic                  zl;

  // stage 1: lane products of the two unit vectors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ni1_r[k] <= ni_i[k];
        nn1_r[k] <= nn_i[k];
        p1_r[k]  <= (2*F+4)'(ni_i[k]) * (2*F+4)'(nn_i[k]);
      end
      ctl_r[0]  <= ctl_i;
      len_r[0]  <= len_i;
      fast_r[0] <= fast_i;
    end
  end

  // stage 2: 2 * floor(dot)
  assign dsum = (2*F+6)'(p1_r[0]) + (2*F+6)'(p1_r[1]) + (2*F+6)'(p1_r[2]);
  assign dsh  = dsum >>> F;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ni2_r[k] <= ni1_r[k];
        nn2_r[k] <= nn1_r[k];
      end
      d2_r      <= {dsh[F+2:0], 1'b0};
      ctl_r[1]  <= ctl_r[0];
      len_r[1]  <= len_r[0];
      fast_r[1] <= fast_r[0];
    end
  end

  // stage 3: n * 2d per lane
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ni3_r[k] <= ni2_r[k];
        t3_r[k]  <= (2*F+6)'(nn2_r[k]) * (2*F+6)'(d2_r);
      end
      ctl_r[2]  <= ctl_r[1];
      len_r[2]  <= len_r[1];
      fast_r[2] <= fast_r[1];
    end
  end

  // stage 4: finish reflect and pick the result for the operation
  always_comb begin
    res_nxt = fast_r[2];
    rv      = '0;
    vs      = '0;
    st      = 1'b0;
    zl      = 1'b0;
    for (int k = 0; k < 3; k++) vx[k] = '0;
    case (ctl_r[2].func)
      FN_LENGTH: begin
        if (len_r[2][W-1]) begin
          vs = WORD_MAX;
          st = 1'b1;
        end else begin
          vs = len_r[2];
        end
        res_nxt = {st, zl, vs, vx[2], vx[1], vx[0]};
      end
      FN_NORM: begin
        if (ctl_r[2].len_a_zero) begin
          zl = 1'b1;
        end else begin
          for (int k = 0; k < 3; k++) vx[k] = W'(ni3_r[k]);
        end
        res_nxt = {st, zl, vs, vx[2], vx[1], vx[0]};
      end
      FN_REFLECT: begin
        if (ctl_r[2].len_a_zero || ctl_r[2].len_b_zero) begin
          zl = 1'b1;
        end else begin
          for (int k = 0; k < 3; k++) begin
            rv = RW'(ni3_r[k]) - RW'(t3_r[k] >>> F);
            if (rv > SAT_MAX) begin
              vx[k] = SAT_MAX[W-1:0];
              st    = 1'b1;
            end else if (rv < SAT_MIN) begin
              vx[k] = SAT_MIN[W-1:0];
              st    = 1'b1;
            end else begin
              vx[k] = rv[W-1:0];
            end
          end
        end
        res_nxt = {st, zl, vs, vx[2], vx[1], vx[0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

@@ hw/rtl/vector3_reflect_unit_core.sv @@
// Vector unit for signed fixed-point 3D vectors (default Q16.16).
// Input channel in_*: one item carries an operation code, vectors A and B
// and a scale factor. Result channel out_*: one item per input item, in
// order, with a result vector, a scalar and the zero_length/saturated flags.
// Operations: add, subtract, dot, scale, length, normalize A, and reflect A
// about B (both normalized first). Results clamp to the word range.
// At Q16.16 as at any other format, the pipeline is the two input stages,
// then the square-root pipeline (one root bit per stage) followed by the
// divide lanes (one quotient bit per stage, six lanes for the two vectors)
// and the reflect merge stages. Every operation goes through the same depth.
// Throughput is one item per cycle while the receiver takes results.
// The whole pipeline advances together: when the result register holds an
// item that the receiver does not take, in_tready falls and every stage
// holds; when the result register is empty or being taken, items flow.
// Reset (rst_n low, synchronous) empties the pipeline; the block holds no
// other state and needs no setup.
module vector3_reflect_unit_core #(
  parameter int DATA_WIDTH = vru_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = vru_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // func, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, scale_factor
  input  logic [((3+7*DATA_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // res_x, res_y, res_z, res_scalar, zero_length, saturated
  output logic [((4*DATA_WIDTH+2+7)/8)*8-1:0] out_tdata
);
  import vru_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int SW     = 2*W + 2;
  localparam int RES_W  = 4*W + 2;
  localparam int LAT    = W + F + 7;
  localparam int OUT_TW = ((4*DATA_WIDTH+2+7)/8)*8;
  localparam logic signed [SW-1:0] SAT_MAX = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [SW-1:0] SAT_MIN = $signed({{(SW-W+1){1'b1}}, {(W-1){1'b0}}});

  function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] v);
    if (v > SAT_MAX) return {1'b1, SAT_MAX[W-1:0]};
    else if (v < SAT_MIN) return {1'b1, SAT_MIN[W-1:0]};
    else return {1'b0, v[W-1:0]};
  endfunction

  // global advance: result register empty or being taken
  logic en;
  logic [LAT-1:0] vld_r;

  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // unpack the input item
  func_e              in_func;
  logic signed [W-1:0] in_a [3];
  logic signed [W-1:0] in_b [3];
  logic signed [W-1:0] in_sf;

  assign in_func = func_e'(in_tdata[2:0]);
  assign in_sf   = in_tdata[3+6*W +: W];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_a[k] = in_tdata[3+k*W +: W];
      in_b[k] = in_tdata[3+(3+k)*W +: W];
    end
  end

  // stage 1: per-lane products, squares, sums and differences
  func_e                 func1_r;
  logic signed [W-1:0]   a1_r   [3];
  logic signed [W-1:0]   b1_r   [3];
  logic [2*W-1:0]        sqa1_r [3];
  logic [2*W-1:0]        sqb1_r [3];
  logic signed [2*W-1:0] pab1_r [3];
  logic signed [2*W-1:0] paf1_r [3];
  logic signed [W:0]     add1_r [3];
  logic signed [W:0]     sub1_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      func1_r <= in_func;
      for (int k = 0; k < 3; k++) begin
        a1_r[k]   <= in_a[k];
        b1_r[k]   <= in_b[k];
        sqa1_r[k] <= (2*W)'(in_a[k]) * (2*W)'(in_a[k]);
        sqb1_r[k] <= (2*W)'(in_b[k]) * (2*W)'(in_b[k]);
        pab1_r[k] <= (2*W)'(in_a[k]) * (2*W)'(in_b[k]);
        paf1_r[k] <= (2*W)'(in_a[k]) * (2*W)'(in_sf);
        add1_r[k] <= (W+1)'(in_a[k]) + (W+1)'(in_b[k]);
        sub1_r[k] <= (W+1)'(in_a[k]) - (W+1)'(in_b[k]);
      end
    end
  end

  // stage 2: finish the single-pass operations, sum the squares
  logic signed [SW-1:0] dsum;
  logic [W:0]           sv;
  logic [W-1:0]         fv [3];
  logic [W-1:0]         fs;
  logic                 fst;
  logic [RES_W-1:0]     fast2_nxt;

  assign dsum = SW'(pab1_r[0]) + SW'(pab1_r[1]) + SW'(pab1_r[2]);

  always_comb begin
    sv  = '0;
    fs  = '0;
    fst = 1'b0;
    for (int k = 0; k < 3; k++) fv[k] = '0;
    case (func1_r)
      FN_ADD: begin
        for (int k = 0; k < 3; k++) begin
          sv    = sat_fn(SW'(add1_r[k]));
          fv[k] = sv[W-1:0];
          fst   = fst | sv[W];
        end
      end
      FN_SUB: begin
        for (int k = 0; k < 3; k++) begin
          sv    = sat_fn(SW'(sub1_r[k]));
          fv[k] = sv[W-1:0];
          fst   = fst | sv[W];
        end
      end
      FN_DOT: begin
        sv  = sat_fn(dsum >>> F);
        fs  = sv[W-1:0];
        fst = sv[W];
      end
      FN_SCALE: begin
        for (int k = 0; k < 3; k++) begin
          sv    = sat_fn(SW'(paf1_r[k] >>> F));
          fv[k] = sv[W-1:0];
          fst   = fst | sv[W];
        end
      end
      default: ;
    endcase
    fast2_nxt = {fst, 1'b0, fs, fv[2], fv[1], fv[0]};
  end

  func_e            func2_r;
  logic [6*W-1:0]   ab2_r;
  logic [RES_W-1:0] fast2_r;
  logic [2*W-1:0]   sqa2_r;
  logic [2*W-1:0]   sqb2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      func2_r <= func1_r;
      ab2_r   <= {b1_r[2], b1_r[1], b1_r[0], a1_r[2], a1_r[1], a1_r[0]};
      fast2_r <= fast2_nxt;
      sqa2_r  <= sqa1_r[0] + sqa1_r[1] + sqa1_r[2];
      sqb2_r  <= sqb1_r[0] + sqb1_r[1] + sqb1_r[2];
    end
  end

  // vector lengths
  logic [W-1:0] len_a;
  logic [W-1:0] len_b;

  vru_isqrt #(.W(W)) u_isqrt_a (.clk(clk), .en(en), .rad_i(sqa2_r), .root_o(len_a));
  vru_isqrt #(.W(W)) u_isqrt_b (.clk(clk), .en(en), .rad_i(sqb2_r), .root_o(len_b));

  // sideband alongside the square roots
  logic [6*W-1:0]   lna_ab_r   [W];
  func_e            lna_func_r [W];
  logic [RES_W-1:0] lna_fast_r [W];

  always_ff @(posedge clk) begin
    if (en) begin
      lna_ab_r[0]   <= ab2_r;
      lna_func_r[0] <= func2_r;
      lna_fast_r[0] <= fast2_r;
      for (int i = 1; i < W; i++) begin
        lna_ab_r[i]   <= lna_ab_r[i-1];
        lna_func_r[i] <= lna_func_r[i-1];
        lna_fast_r[i] <= lna_fast_r[i-1];
      end
    end
  end

  // six divide lanes: A components by |A|, B components by |B|
  logic signed [F+1:0] nq [6];

  for (genvar j = 0; j < 6; j++) begin : g_lane
    logic signed [W-1:0] comp;
    logic [W-1:0]        mag;

    assign comp = lna_ab_r[W-1][j*W +: W];
    assign mag  = comp[W-1] ? W'(-comp) : W'(comp);

    vru_div_lane #(.W(W), .F(F)) u_lane (
      .clk   (clk),
      .en    (en),
      .mag_i (mag),
      .neg_i (comp[W-1]),
      .den_i ((j < 3) ? len_a : len_b),
      .q_o   (nq[j])
    );
  end

  // sideband alongside the divide lanes
  ctl_t             ctl_ent;
  ctl_t             lnb_ctl_r  [F+1];
  logic [W-1:0]     lnb_len_r  [F+1];
  logic [RES_W-1:0] lnb_fast_r [F+1];

  assign ctl_ent = '{func: lna_func_r[W-1], len_a_zero: (len_a == '0),
                     len_b_zero: (len_b == '0)};

  always_ff @(posedge clk) begin
    if (en) begin
      lnb_ctl_r[0]  <= ctl_ent;
      lnb_len_r[0]  <= len_a;
      lnb_fast_r[0] <= lna_fast_r[W-1];
      for (int i = 1; i <= F; i++) begin
        lnb_ctl_r[i]  <= lnb_ctl_r[i-1];
        lnb_len_r[i]  <= lnb_len_r[i-1];
        lnb_fast_r[i] <= lnb_fast_r[i-1];
      end
    end
  end

  // merge lanes, reflect, select; its last stage is the result register
  logic signed [F+1:0] ni [3];
  logic signed [F+1:0] nn [3];
  logic [RES_W-1:0]    res;

  assign ni = '{nq[0], nq[1], nq[2]};
  assign nn = '{nq[3], nq[4], nq[5]};

  vru_merge #(.W(W), .F(F)) u_merge (
    .clk    (clk),
    .en     (en),
    .ctl_i  (lnb_ctl_r[F]),
    .len_i  (lnb_len_r[F]),
    .fast_i (lnb_fast_r[F]),
    .ni_i   (ni),
    .nn_i   (nn),
    .res_o  (res)
  );

  assign out_tdata = OUT_TW'(res);

  // a zero-length item carries a zero vector
  a_zl_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res[4*W] |-> res[3*W-1:0] == '0)
    else $error("zero_length with nonzero vector");

  // the two flags never meet
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(res[4*W] && res[4*W+1]))
    else $error("zero_length and saturated both set");

  // a result is either a vector or a scalar
  a_vec_or_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res[3*W-1:0] == '0) || (res[4*W-1:3*W] == '0))
    else $error("vector and scalar both nonzero");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule
